// File: hdl/i2c_bus_recovery_macros.svh
// ----------------------------------------------------------------------------
// i2c_bus_recovery_macros.svh
// assertion macros shared by the bus recovery checker
// ----------------------------------------------------------------------------
`ifndef I2C_BUS_RECOVERY_MACROS_SVH
`define I2C_BUS_RECOVERY_MACROS_SVH

// condition holds at every clock edge out of reset
`define I2CBR_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("i2c bus recovery: invariant violated");

// antecedent implies consequent on the same edge
`define I2CBR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2c bus recovery: implication violated");

// antecedent implies consequent on the next edge
`define I2CBR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2c bus recovery: next-cycle check violated");

`endif

// File: hdl/i2cbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbr_pkg
// types, codes and helpers for the i2c bus-clear sequencer
// ----------------------------------------------------------------------------
package i2cbr_pkg;

	// delay timer width
	localparam int unsigned TIMER_BITS = 16;
	localparam int unsigned HALF_W     = 16;
	localparam int unsigned CNT_W      = 4;
	localparam int unsigned PHASE_W    = 4;
	localparam int unsigned OUTCOME_W  = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [PHASE_W-1:0]    phase_t;
	typedef logic [OUTCOME_W-1:0]  outcome_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

	localparam timer_t TIMER_ONE = timer_t'(1);

	// register indexes
	localparam cfg_idx_t REG_HALF_PERIOD = 2'd0;
	localparam cfg_idx_t REG_STRETCH     = 2'd1;
	localparam cfg_idx_t REG_MAX_PULSES  = 2'd2;

	// reset values of the registers
	localparam logic [HALF_W-1:0] HALF_PERIOD_RST = 16'd5;
	localparam cnt_t              STRETCH_RST     = 4'd3;
	localparam cnt_t              MAX_PULSES_RST  = 4'd9;

	// sequencer phases
	localparam phase_t PH_IDLE       = 4'd0;
	localparam phase_t PH_TRY_INIT   = 4'd1;
	localparam phase_t PH_DELAY_PRE  = 4'd2;
	localparam phase_t PH_TRY_PULSE  = 4'd3;
	localparam phase_t PH_CLK_HIGH   = 4'd4;
	localparam phase_t PH_CLK_LOW    = 4'd5;
	localparam phase_t PH_STOP_SETUP = 4'd6;
	localparam phase_t PH_TRY_STOP   = 4'd7;
	localparam phase_t PH_STOP_HIGH  = 4'd8;
	localparam phase_t PH_STOP_CHECK = 4'd9;
	localparam phase_t PH_STOP_TAIL  = 4'd10;

	// outcome codes
	localparam outcome_t OUT_NONE    = 3'd0;
	localparam outcome_t OUT_FINE    = 3'd1;
	localparam outcome_t OUT_RECOV   = 3'd2;
	localparam outcome_t OUT_STUCK   = 3'd3;
	localparam outcome_t OUT_SDA_LOW = 3'd4;

	// half-period load value: zero acts as one, saturate to timer range
	function automatic timer_t delay_load(input logic [HALF_W-1:0] half);
		logic [31:0] lim;
		logic [31:0] v;
		lim = 32'hFFFF_FFFF >> (32 - TIMER_BITS);
		v   = {{(32-HALF_W){1'b0}}, half};
		if (v > lim) begin
			v = lim;
		end
		if (v == 32'd0) begin
			v = 32'd1;
		end
		return v[TIMER_BITS-1:0];
	endfunction

endpackage

// File: hdl/i2c_bus_recovery.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bus_recovery
// bus-clear sequencer: release, scl stretch retries, up to N clock pulses,
// stop generation, outcome report; one time tick per input beat
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | action, force_req, scl_level, sda_level
// out     | output    | out_valid / out_stall| scl_pull_low, sda_pull_low, busy_res,
//         |           |                      | finished, outcome
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// one tick beat is taken every cycle unless in_stall is high; its result beat appears in the next cycle
// from the output register, set by the single next-state stage
// in_stall is high only while a result beat is held and out_stall is high
// arst_n clears the sequencer to idle and the registers to 5 / 3 / 9
// ----------------------------------------------------------------------------
module i2c_bus_recovery (
	input  logic                              clk,
	input  logic                              arst_n,
	// tick channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic                              force_req,
	input  logic                              scl_level,
	input  logic                              sda_level,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              scl_pull_low,
	output logic                              sda_pull_low,
	output logic                              busy_res,
	output logic                              finished,
	output logic [i2cbr_pkg::OUTCOME_W-1:0]   outcome,
	// register writes
	input  logic                              cfg_we,
	input  logic [i2cbr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [i2cbr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// configuration registers
	logic [i2cbr_pkg::HALF_W-1:0] half_q;
	i2cbr_pkg::cnt_t              stretch_q;
	i2cbr_pkg::cnt_t              max_pulses_q;

	// sequencer state
	i2cbr_pkg::phase_t   phase_q, phase_n;
	i2cbr_pkg::timer_t   wait_q, wait_n;
	i2cbr_pkg::cnt_t     pulse_q, pulse_n;
	i2cbr_pkg::cnt_t     try_q, try_n;
	logic                scl_q, scl_n;
	logic                sda_q, sda_n;
	i2cbr_pkg::outcome_t last_q, last_n;
	logic                fin;

	// helpers
	i2cbr_pkg::timer_t   load;
	logic                dly_done;
	i2cbr_pkg::timer_t   dly_next;
	logic                try_pend;
	i2cbr_pkg::cnt_t     try_cnt;
	logic                try_stuck;
	i2cbr_pkg::cnt_t     pulse_inc;

	// output register
	logic                out_valid_q;
	logic                scl_out_q, sda_out_q, busy_q, fin_q;
	i2cbr_pkg::outcome_t outcome_q;

	logic                in_acc;

	assign in_stall = out_valid_q & out_stall;
	assign in_acc   = in_valid & ~in_stall;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q       <= i2cbr_pkg::HALF_PERIOD_RST;
			stretch_q    <= i2cbr_pkg::STRETCH_RST;
			max_pulses_q <= i2cbr_pkg::MAX_PULSES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				i2cbr_pkg::REG_HALF_PERIOD: half_q <= cfg_data;
				i2cbr_pkg::REG_STRETCH:     stretch_q <= cfg_data[i2cbr_pkg::CNT_W-1:0];
				i2cbr_pkg::REG_MAX_PULSES:  max_pulses_q <= cfg_data[i2cbr_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// shared delay and retry terms
	assign load      = i2cbr_pkg::delay_load(half_q);
	assign dly_done  = (wait_q <= i2cbr_pkg::TIMER_ONE);
	assign dly_next  = dly_done ? '0 : (wait_q - i2cbr_pkg::TIMER_ONE);
	assign try_pend  = (wait_q > i2cbr_pkg::TIMER_ONE);
	assign try_cnt   = (wait_q != '0) ? (try_q + 4'd1) : try_q;
	assign try_stuck = (try_cnt >= stretch_q);
	assign pulse_inc = pulse_q + 4'd1;

	// next state for one tick
	always_comb begin
		phase_n = phase_q;
		wait_n  = wait_q;
		pulse_n = pulse_q;
		try_n   = try_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		last_n  = last_q;
		fin     = 1'b0;
		unique case (phase_q)
			i2cbr_pkg::PH_IDLE: begin
				if (action) begin
					if (!force_req && scl_level && sda_level) begin
						last_n = i2cbr_pkg::OUT_FINE;
						fin    = 1'b1;
					end else begin
						scl_n = 1'b0;
						sda_n = 1'b0;
						if (!scl_level) begin
							phase_n = i2cbr_pkg::PH_TRY_INIT;
							try_n   = '0;
							wait_n  = '0;
						end else begin
							phase_n = i2cbr_pkg::PH_DELAY_PRE;
							wait_n  = load;
						end
					end
				end
			end
			i2cbr_pkg::PH_TRY_INIT, i2cbr_pkg::PH_TRY_PULSE, i2cbr_pkg::PH_TRY_STOP: begin
				scl_n = 1'b0;
				if (try_pend) begin
					wait_n = dly_next;
				end else begin
					try_n = try_cnt;
					if (try_stuck) begin
						last_n = i2cbr_pkg::OUT_STUCK;
						fin    = 1'b1;
					end else begin
						wait_n = load;
						if (scl_level) begin
							unique case (phase_q)
								i2cbr_pkg::PH_TRY_INIT:  phase_n = i2cbr_pkg::PH_DELAY_PRE;
								i2cbr_pkg::PH_TRY_PULSE: phase_n = i2cbr_pkg::PH_CLK_HIGH;
								default:                 phase_n = i2cbr_pkg::PH_STOP_HIGH;
							endcase
						end
					end
				end
			end
			i2cbr_pkg::PH_DELAY_PRE: begin
				wait_n = dly_next;
				if (dly_done) begin
					pulse_n = '0;
					if (max_pulses_q == '0) begin
						sda_n   = 1'b1;
						phase_n = i2cbr_pkg::PH_STOP_SETUP;
						wait_n  = load;
					end else begin
						phase_n = i2cbr_pkg::PH_TRY_PULSE;
						try_n   = '0;
						wait_n  = '0;
					end
				end
			end
			i2cbr_pkg::PH_CLK_HIGH: begin
				wait_n = dly_next;
				if (dly_done) begin
					scl_n   = 1'b1;
					phase_n = i2cbr_pkg::PH_CLK_LOW;
					wait_n  = load;
				end
			end
			i2cbr_pkg::PH_CLK_LOW: begin
				wait_n = dly_next;
				if (dly_done) begin
					pulse_n = pulse_inc;
					if (sda_level || (pulse_inc >= max_pulses_q)) begin
						sda_n   = 1'b1;
						phase_n = i2cbr_pkg::PH_STOP_SETUP;
						wait_n  = load;
					end else begin
						phase_n = i2cbr_pkg::PH_TRY_PULSE;
						try_n   = '0;
						wait_n  = '0;
					end
				end
			end
			i2cbr_pkg::PH_STOP_SETUP: begin
				wait_n = dly_next;
				if (dly_done) begin
					phase_n = i2cbr_pkg::PH_TRY_STOP;
					try_n   = '0;
					wait_n  = '0;
				end
			end
			i2cbr_pkg::PH_STOP_HIGH: begin
				wait_n = dly_next;
				if (dly_done) begin
					sda_n   = 1'b0;
					phase_n = i2cbr_pkg::PH_STOP_CHECK;
				end
			end
			i2cbr_pkg::PH_STOP_CHECK: begin
				last_n  = sda_level ? i2cbr_pkg::OUT_RECOV : i2cbr_pkg::OUT_SDA_LOW;
				phase_n = i2cbr_pkg::PH_STOP_TAIL;
				wait_n  = load;
			end
			i2cbr_pkg::PH_STOP_TAIL: begin
				wait_n = dly_next;
				if (dly_done) begin
					fin = 1'b1;
				end
			end
			default: begin
				phase_n = i2cbr_pkg::PH_IDLE;
			end
		endcase
		// sequence end releases both lines
		if (fin) begin
			phase_n = i2cbr_pkg::PH_IDLE;
			scl_n   = 1'b0;
			sda_n   = 1'b0;
			wait_n  = '0;
		end
	end

	// state update on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cbr_pkg::PH_IDLE;
			wait_q  <= '0;
			pulse_q <= '0;
			try_q   <= '0;
			scl_q   <= 1'b0;
			sda_q   <= 1'b0;
			last_q  <= i2cbr_pkg::OUT_NONE;
		end else if (in_acc) begin
			phase_q <= phase_n;
			wait_q  <= wait_n;
			pulse_q <= pulse_n;
			try_q   <= try_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			last_q  <= last_n;
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			scl_out_q <= scl_n;
			sda_out_q <= sda_n;
			busy_q    <= (phase_n != i2cbr_pkg::PH_IDLE);
			fin_q     <= fin;
			outcome_q <= fin ? last_n : i2cbr_pkg::OUT_NONE;
		end
	end

	assign out_valid    = out_valid_q;
	assign scl_pull_low = scl_out_q;
	assign sda_pull_low = sda_out_q;
	assign busy_res     = busy_q;
	assign finished     = fin_q;
	assign outcome      = outcome_q;

endmodule

// File: hdl/i2cbr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbr_checker
// port-level checks on the bus recovery result channel
// ----------------------------------------------------------------------------
`include "i2c_bus_recovery_macros.svh"

module i2cbr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic                            scl_pull_low,
	input logic                            sda_pull_low,
	input logic                            busy_res,
	input logic                            finished,
	input logic [i2cbr_pkg::OUTCOME_W-1:0] outcome
);

	// a finishing beat ends the sequence and releases both lines
	`I2CBR_ASSERT_IMPL(a_fin_idle, out_valid && finished, !busy_res && !scl_pull_low && !sda_pull_low)

	// an outcome is reported only on a finishing beat
	`I2CBR_ASSERT_IMPL(a_outcome_fin, out_valid && (outcome != i2cbr_pkg::OUT_NONE), finished)

	// a finishing beat always carries a real outcome
	`I2CBR_ASSERT_IMPL(a_fin_code, out_valid && finished, (outcome >= i2cbr_pkg::OUT_FINE) && (outcome <= i2cbr_pkg::OUT_SDA_LOW))

	// a held result beat keeps the tick input stalled
	`I2CBR_ASSERT_IMPL(a_stall, out_valid && out_stall, in_stall)

	// a held result beat stays put
	`I2CBR_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(outcome) && $stable(finished))

endmodule

bind i2c_bus_recovery i2cbr_checker u_i2cbr_checker (.*);

// File: verif/tb_i2c_bus_recovery.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_bus_recovery
// self-checking bench for the i2c bus-clear sequencer
// ----------------------------------------------------------------------------
// directed tests cover plain ticks, skipped and forced recovery, a target that
// never lets go of sda, clock stuck at every release point, and the register
// extremes (zero and long half period, zero and fifteen tries/pulses).
// random tests then run recovery sequences against a small bus model with
// clock-stretching targets, glitches and stray requests. every tick beat is
// run through an in-bench model of the sequencer and each result beat is
// compared field by field, in order, with the oldest predicted report
// ----------------------------------------------------------------------------
module tb_i2c_bus_recovery;

	// no beat on any channel for this long means the block hung; the limit is far
	// above the longest sender gap plus the longest result stall
	localparam int unsigned         WATCHDOG_LIMIT = 4000;
	localparam int unsigned         RANDOM_TICKS   = 600;
	localparam int unsigned         DRAIN_CYCLES   = 4;
	localparam i2cbr_pkg::cfg_idx_t REG_SPARE      = 2'd3;

	typedef struct packed {
		logic                 scl_pull;
		logic                 sda_pull;
		logic                 busy;
		logic                 fin;
		i2cbr_pkg::outcome_t  code;
	} drive_report_t;

	typedef enum logic [1:0] {
		RELEASE_PENDING,
		RELEASE_SCL_HIGH,
		RELEASE_STUCK
	} release_t;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             in_valid  = 1'b0;
	logic                             in_stall;
	logic                             action    = 1'b0;
	logic                             force_req = 1'b0;
	logic                             scl_level = 1'b1;
	logic                             sda_level = 1'b1;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic                             scl_pull_low;
	logic                             sda_pull_low;
	logic                             busy_res;
	logic                             finished;
	logic [i2cbr_pkg::OUTCOME_W-1:0]  outcome;
	logic                             cfg_we    = 1'b0;
	logic [i2cbr_pkg::CFG_IDX_W-1:0]  cfg_index = i2cbr_pkg::REG_HALF_PERIOD;
	logic [i2cbr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	// sequencer model state and its copy of the registers
	i2cbr_pkg::phase_t            seq_phase   = i2cbr_pkg::PH_IDLE;
	i2cbr_pkg::timer_t            hold_left   = '0;
	i2cbr_pkg::cnt_t              pulses_done = '0;
	i2cbr_pkg::cnt_t              tries_done  = '0;
	logic                         scl_low_drv = 1'b0;
	logic                         sda_low_drv = 1'b0;
	i2cbr_pkg::outcome_t          last_code   = i2cbr_pkg::OUT_NONE;
	logic [i2cbr_pkg::HALF_W-1:0] half_reg    = i2cbr_pkg::HALF_PERIOD_RST;
	i2cbr_pkg::cnt_t              tries_reg   = i2cbr_pkg::STRETCH_RST;
	i2cbr_pkg::cnt_t              pulses_reg  = i2cbr_pkg::MAX_PULSES_RST;

	drive_report_t         expected_reports[$];
	int unsigned           recovery_ticks = 0;
	int unsigned           mismatches     = 0;
	int unsigned           quiet_cycles   = 0;
	bit                    gaps_on        = 1'b1;

	initial begin
		forever #5 clk = ~clk;
	end

	i2c_bus_recovery uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.force_req    (force_req),
		.scl_level    (scl_level),
		.sda_level    (sda_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.scl_pull_low (scl_pull_low),
		.sda_pull_low (sda_pull_low),
		.busy_res     (busy_res),
		.finished     (finished),
		.outcome      (outcome),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// ------------------------------------------------------------------------
	// sequencer model
	// ------------------------------------------------------------------------

	// half period in ticks: zero counts as one, clipped to the timer range
	function automatic i2cbr_pkg::timer_t half_period_count();
		longint unsigned top;
		longint unsigned span;
		top  = (64'd1 << i2cbr_pkg::TIMER_BITS) - 64'd1;
		span = (half_reg > top) ? top : half_reg;
		return (span == 0) ? i2cbr_pkg::timer_t'(1) : i2cbr_pkg::timer_t'(span);
	endfunction

	function automatic void arm_delay(i2cbr_pkg::phase_t nxt);
		seq_phase = nxt;
		hold_left = half_period_count();
	endfunction

	function automatic void arm_release(i2cbr_pkg::phase_t nxt);
		seq_phase  = nxt;
		tries_done = '0;
		hold_left  = '0;
	endfunction

	// the tick that finds the count at one or zero ends the delay
	function automatic bit delay_elapsed();
		if (hold_left > 1) begin
			hold_left = hold_left - 1'b1;
			return 1'b0;
		end
		hold_left = '0;
		return 1'b1;
	endfunction

	// one tick of letting go of scl and waiting for it to rise
	function automatic release_t release_step(logic scl);
		scl_low_drv = 1'b0;
		if (hold_left != '0) begin
			if (!delay_elapsed()) begin
				return RELEASE_PENDING;
			end
			tries_done = tries_done + 1'b1;
		end
		if (tries_done >= tries_reg) begin
			return RELEASE_STUCK;
		end
		if (scl) begin
			return RELEASE_SCL_HIGH;
		end
		hold_left = half_period_count();
		return RELEASE_PENDING;
	endfunction

	function automatic drive_report_t advance_sequencer(logic req, logic frc, logic scl,
			logic sda);
		drive_report_t rep;
		logic          done;
		release_t      rel;
		done = 1'b0;
		case (seq_phase)
			i2cbr_pkg::PH_IDLE: begin
				if (req) begin
					if (!frc && scl && sda) begin
						last_code = i2cbr_pkg::OUT_FINE;
						done      = 1'b1;
					end else begin
						scl_low_drv = 1'b0;
						sda_low_drv = 1'b0;
						if (!scl) begin
							arm_release(i2cbr_pkg::PH_TRY_INIT);
						end else begin
							arm_delay(i2cbr_pkg::PH_DELAY_PRE);
						end
					end
				end
			end
			i2cbr_pkg::PH_TRY_INIT, i2cbr_pkg::PH_TRY_PULSE, i2cbr_pkg::PH_TRY_STOP: begin
				rel = release_step(scl);
				if (rel == RELEASE_STUCK) begin
					last_code = i2cbr_pkg::OUT_STUCK;
					done      = 1'b1;
				end else if (rel == RELEASE_SCL_HIGH) begin
					case (seq_phase)
						i2cbr_pkg::PH_TRY_INIT:  arm_delay(i2cbr_pkg::PH_DELAY_PRE);
						i2cbr_pkg::PH_TRY_PULSE: arm_delay(i2cbr_pkg::PH_CLK_HIGH);
						default:                 arm_delay(i2cbr_pkg::PH_STOP_HIGH);
					endcase
				end
			end
			i2cbr_pkg::PH_DELAY_PRE: begin
				if (delay_elapsed()) begin
					pulses_done = '0;
					if (pulses_reg == '0) begin
						sda_low_drv = 1'b1;
						arm_delay(i2cbr_pkg::PH_STOP_SETUP);
					end else begin
						arm_release(i2cbr_pkg::PH_TRY_PULSE);
					end
				end
			end
			i2cbr_pkg::PH_CLK_HIGH: begin
				if (delay_elapsed()) begin
					scl_low_drv = 1'b1;
					arm_delay(i2cbr_pkg::PH_CLK_LOW);
				end
			end
			// end of a pulse: stop early once the target has let go of sda
			i2cbr_pkg::PH_CLK_LOW: begin
				if (delay_elapsed()) begin
					pulses_done = pulses_done + 1'b1;
					if (sda || pulses_done >= pulses_reg) begin
						sda_low_drv = 1'b1;
						arm_delay(i2cbr_pkg::PH_STOP_SETUP);
					end else begin
						arm_release(i2cbr_pkg::PH_TRY_PULSE);
					end
				end
			end
			i2cbr_pkg::PH_STOP_SETUP: begin
				if (delay_elapsed()) begin
					arm_release(i2cbr_pkg::PH_TRY_STOP);
				end
			end
			i2cbr_pkg::PH_STOP_HIGH: begin
				if (delay_elapsed()) begin
					sda_low_drv = 1'b0;
					seq_phase   = i2cbr_pkg::PH_STOP_CHECK;
				end
			end
			i2cbr_pkg::PH_STOP_CHECK: begin
				last_code = sda ? i2cbr_pkg::OUT_RECOV : i2cbr_pkg::OUT_SDA_LOW;
				arm_delay(i2cbr_pkg::PH_STOP_TAIL);
			end
			i2cbr_pkg::PH_STOP_TAIL: begin
				if (delay_elapsed()) begin
					done = 1'b1;
				end
			end
			default: begin
				seq_phase = i2cbr_pkg::PH_IDLE;
			end
		endcase

		// sequence over: back to idle with both lines released
		if (done) begin
			seq_phase   = i2cbr_pkg::PH_IDLE;
			scl_low_drv = 1'b0;
			sda_low_drv = 1'b0;
			hold_left   = '0;
		end
		rep.scl_pull = scl_low_drv;
		rep.sda_pull = sda_low_drv;
		rep.busy     = (seq_phase != i2cbr_pkg::PH_IDLE);
		rep.fin      = done;
		rep.code     = done ? last_code : i2cbr_pkg::OUT_NONE;
		return rep;
	endfunction

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// send one tick beat after a random gap and predict its report
	task automatic send_tick(logic req, logic frc, logic scl, logic sda);
		int unsigned roll;
		int unsigned gap;
		roll = $urandom_range(0, 99);
		if (!gaps_on || roll < 70) begin
			gap = 0;
		end else if (roll < 94) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(8, 30);
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		action    <= req;
		force_req <= frc;
		scl_level <= scl;
		sda_level <= sda;
		do @(posedge clk); while (in_stall);
		expected_reports.push_back(advance_sequencer(req, frc, scl, sda));
	endtask

	// cfg_we is left high; the caller lowers it after the last write
	task automatic write_reg(i2cbr_pkg::cfg_idx_t idx,
			logic [i2cbr_pkg::CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			i2cbr_pkg::REG_HALF_PERIOD: half_reg   = value;
			i2cbr_pkg::REG_STRETCH:     tries_reg  = i2cbr_pkg::cnt_t'(value);
			i2cbr_pkg::REG_MAX_PULSES:  pulses_reg = i2cbr_pkg::cnt_t'(value);
			default: ;
		endcase
	endtask

	// new settings once every report is back; spare index must have no effect
	task automatic write_registers(logic [i2cbr_pkg::HALF_W-1:0] half,
			i2cbr_pkg::cnt_t tries, i2cbr_pkg::cnt_t pulses);
		in_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		write_reg(i2cbr_pkg::REG_HALF_PERIOD, half);
		write_reg(i2cbr_pkg::REG_STRETCH, {12'($urandom), tries});
		write_reg(i2cbr_pkg::REG_MAX_PULSES, {12'($urandom), pulses});
		write_reg(REG_SPARE, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic idle_ticks(int unsigned count);
		repeat (count) begin
			send_tick(1'b0, 1'($urandom), 1'($urandom), 1'($urandom));
		end
	endtask

	// one request and the ticks that follow it until the sequencer is idle.
	// the bus levels come from the model's drives and a target that:
	//   holds sda low until it has seen sda_free_after pulses (-1: never),
	//   holds scl low for scl_hold ticks from the request,
	//   stretches scl now and then (stretch_pct per tick),
	//   holds scl low for good once it has seen stick_at pulses (-1: never)
	// noise_pct glitches a line or adds a stray request on some ticks
	task automatic run_recovery(logic frc, int sda_free_after, int scl_hold, int stick_at,
			int unsigned stretch_pct, int unsigned noise_pct);
		int   pulses_seen;
		int   held;
		logic prev_drv;
		logic scl;
		logic sda;
		logic req;
		logic f;
		bit   first;
		pulses_seen = 0;
		held        = scl_hold;
		first       = 1'b1;
		do begin
			scl = !scl_low_drv && (held == 0);
			sda = !sda_low_drv && (sda_free_after >= 0) && (pulses_seen >= sda_free_after);
			req = first;
			f   = first ? frc : 1'($urandom);
			if ($urandom_range(0, 99) < noise_pct) begin
				case ($urandom_range(0, 2))
					0:       scl = ~scl;
					1:       sda = ~sda;
					default: req = 1'b1;
				endcase
			end
			prev_drv = scl_low_drv;
			send_tick(req, f, scl, sda);
			recovery_ticks++;
			if (!prev_drv && scl_low_drv) begin
				pulses_seen++;
			end
			if (held > 0) begin
				held--;
			end else if (held == 0 && $urandom_range(0, 99) < stretch_pct) begin
				held = $urandom_range(1, 6);
			end
			if (stick_at >= 0 && pulses_seen >= stick_at) begin
				held = -1;
			end
			first = 1'b0;
		end while (seq_phase != i2cbr_pkg::PH_IDLE);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// plain ticks give all-zero reports; a request with both lines high is skipped
	task automatic test_idle_ticks();
		for (int i = 0; i < 8; i++) begin
			send_tick(1'b0, i[2], i[1], i[0]);
		end
		send_tick(1'b1, 1'b0, 1'b1, 1'b1);
	endtask

	// reset settings: forced run on a clean bus, and a target letting go late
	task automatic test_forced_recovery();
		run_recovery(1'b1, 0, 0, -1, 0, 0);
		run_recovery(1'b0, 3, 2, -1, 0, 0);
	endtask

	// sda never released: full pulse train, then no pulses at all
	task automatic test_sda_stuck();
		write_registers(16'd1, 4'd3, 4'd15);
		run_recovery(1'b0, -1, 0, -1, 0, 0);
		run_recovery(1'b0, 4, 0, -1, 0, 25);
		write_registers(16'd1, 4'd3, 4'd0);
		run_recovery(1'b1, 0, 0, -1, 0, 0);
		run_recovery(1'b0, -1, 0, -1, 0, 0);
	endtask

	// clock stuck with no tries, with the most tries, mid-pulse and at the stop
	task automatic test_clock_stuck();
		write_registers(16'd2, 4'd0, 4'd9);
		run_recovery(1'b0, -1, 1, 0, 0, 0);
		write_registers(16'd2, 4'd15, 4'd3);
		run_recovery(1'b0, -1, 1, 0, 0, 0);
		run_recovery(1'b0, -1, 0, 2, 0, 0);
		run_recovery(1'b0, -1, 0, 3, 0, 0);
		run_recovery(1'b0, 2, 0, -1, 30, 0);
	endtask

	// a zero half period acts as one tick
	task automatic test_zero_half_period();
		write_registers(16'd0, 4'd2, 4'd2);
		run_recovery(1'b1, 0, 0, -1, 0, 0);
		run_recovery(1'b0, -1, 2, -1, 0, 0);
	endtask

	// long half period: one stuck-clock run through the whole delay
	task automatic test_longest_half_period();
		write_registers(16'd200, 4'd1, 4'd9);
		gaps_on = 1'b0;
		send_tick(1'b1, 1'b0, 1'b1, 1'b1);
		run_recovery(1'b0, -1, 1, 0, 0, 0);
		gaps_on = 1'b1;
	endtask

	// random settings, mostly short half periods, and random target behavior
	task automatic test_random_sequences();
		int unsigned                  target;
		logic [i2cbr_pkg::HALF_W-1:0] half;
		int                           sda_free;
		int                           scl_hold;
		int                           stick;
		int unsigned                  stretch;
		int unsigned                  noise;
		target = recovery_ticks + RANDOM_TICKS;
		while (recovery_ticks < target) begin
			case ($urandom_range(0, 19))
				0, 1:                     half = '0;
				2, 3, 4, 5, 6, 7, 8, 9,
				10, 11:                   half = 16'd1;
				12, 13, 14, 15, 16:       half = 16'($urandom_range(2, 3));
				17, 18:                   half = 16'($urandom_range(4, 8));
				default:                  half = 16'($urandom_range(9, 24));
			endcase
			write_registers(half, i2cbr_pkg::cnt_t'($urandom_range(0, 15)),
				i2cbr_pkg::cnt_t'($urandom_range(0, 15)));
			gaps_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(3, 8)) begin
				case ($urandom_range(0, 9))
					0:       sda_free = 0;
					1:       sda_free = -1;
					default: sda_free = $urandom_range(1, 12);
				endcase
				scl_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
				stick    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : -1;
				stretch  = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 15);
				noise    = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 20);
				run_recovery(1'($urandom), sda_free, scl_hold, stick, stretch, noise);
				idle_ticks($urandom_range(0, 4));
			end
		end
		gaps_on = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// result stall: short stalls, a few long ones, and quiet stretches
	// ------------------------------------------------------------------------
	initial begin
		forever begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					out_stall <= 1'b0;
					repeat ($urandom_range(20, 150)) @(posedge clk);
				end
				9: begin
					out_stall <= 1'b1;
					repeat ($urandom_range(10, 40)) @(posedge clk);
				end
				default: begin
					out_stall <= 1'b1;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end
			endcase
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// ------------------------------------------------------------------------
	// result check against the oldest predicted report
	// ------------------------------------------------------------------------
	function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		drive_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_reports.size() == 0) begin
				$error("result beat with no tick waiting for it");
				mismatches++;
			end else begin
				want = expected_reports.pop_front();
				check_field("scl_pull_low", {2'b00, want.scl_pull}, {2'b00, scl_pull_low});
				check_field("sda_pull_low", {2'b00, want.sda_pull}, {2'b00, sda_pull_low});
				check_field("busy_res", {2'b00, want.busy}, {2'b00, busy_res});
				check_field("finished", {2'b00, want.fin}, {2'b00, finished});
				check_field("outcome", want.code, outcome);
			end
		end
	end

	// hang detection: counts cycles with no beat on any port
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("i2c_bus_recovery test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ticks();
		test_forced_recovery();
		test_sda_stuck();
		test_clock_stuck();
		test_zero_half_period();
		test_longest_half_period();
		test_random_sequences();
		in_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("i2c_bus_recovery test passed");
		end else begin
			$display("i2c_bus_recovery test failed");
		end
		$finish;
	end

endmodule
